[rtl/core/polyphase_row_resampler_8bit_assert.svh]
// Assertion macros used by the resampler top level.
`ifndef POLYPHASE_ROW_RESAMPLER_8BIT_ASSERT_SVH
`define POLYPHASE_ROW_RESAMPLER_8BIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rpr_pkg.sv]
// Shared types and constants of the polyphase row resampler.
package rpr_pkg;

  localparam int IDX_W = 12;
  localparam int PHASE_W = 8;
  localparam int TAPNUM_W = 3;
  localparam int PIX_W = 8;
  localparam int COEF_W = 16;
  localparam int POS_W = 32;
  localparam int STEP_W = 31;
  localparam int SW_W = 13;
  localparam int TC_REG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int PHASES = 256;
  localparam int FRAC_BITS = 14;
  localparam int ROUND_BIAS = 'h2000;
  localparam int PIXEL_MAX = 255;

  localparam int DEF_MAX_SOURCE_WIDTH = 4096;
  localparam int DEF_MAX_TAPS = 8;
  localparam int MAX_DEST_WIDTH = 4096;

  localparam int ITEM_QUEUE_DEPTH = 4;
  localparam int RESULT_QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_LOAD_PIXEL = 2'd0;
  localparam logic [1:0] OP_LOAD_COEF = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH,
    CFG_START_POSITION,
    CFG_POSITION_STEP,
    CFG_TAP_COUNT
  } rpr_cfg_idx_t;

  typedef struct packed {
    logic [SW_W-1:0]     source_width;
    logic [POS_W-1:0]    start_position;
    logic [STEP_W-1:0]   position_step;
    logic [TC_REG_W-1:0] tap_count;
  } rpr_cfg_t;

  typedef enum logic [1:0] {
    K_PIX,
    K_COEF,
    K_COMP
  } rpr_kind_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    rpr_kind_t           kind;
    logic [IDX_W-1:0]    index;
    logic [PHASE_W-1:0]  phase;
    logic [TAPNUM_W-1:0] tap;
    logic [COEF_W-1:0]   data;
    logic signed [15:0]  base;
  } rpr_item_t;

  typedef struct packed {
    logic             push;
    logic [PIX_W-1:0] pixel;
    logic [IDX_W-1:0] index;
  } rpr_res_t;

endpackage

[rtl/core/polyphase_row_resampler_8bit.sv]
// Top level of the 8-bit polyphase row resampler.
// The block resamples one row of 8-bit pixels with a 256-phase polyphase
// filter of signed 2.14 coefficients. Items enter through a queue-like port
// (push/full) and are of three kinds: load a source pixel, load a
// coefficient, or compute one destination pixel; only compute items give a
// result, which leaves through a second queue-like port (empty/pop) with its
// destination index. A front stage drops ignored items (unknown op, indexes
// or taps out of range) and forms the 16.16 position start + step * x; a
// four-entry item queue then decouples it from the back end, which owns the
// row and coefficient memories and one shared multiply-accumulate. A
// compute beat issues one tap per cycle through the single read port of
// each memory, followed by the registered read and the registered multiply
// before the last product reaches the accumulator; this multiply-accumulate
// loop sets the sustained rate. Results wait in a two-entry output queue,
// so the front keeps accepting beats while a result is not yet popped. The
// memories have no reset: every entry must be written before a compute beat
// reads it. Configuration registers are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce.
`include "polyphase_row_resampler_8bit_assert.svh"

module polyphase_row_resampler_8bit
  import rpr_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               op,
  input  logic [IDX_W-1:0]         index,
  input  logic [PHASE_W-1:0]       phase,
  input  logic [TAPNUM_W-1:0]      tap,
  input  logic [PIX_W-1:0]         pixel,
  input  logic signed [COEF_W-1:0] coefficient,
  output logic                     empty,
  input  logic                     pop,
  output logic [PIX_W-1:0]         out_pixel,
  output logic [IDX_W-1:0]         out_index,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int ITEM_W = $bits(rpr_item_t);
  localparam int OUT_W = PIX_W + IDX_W;

  rpr_cfg_t              cfg;
  logic                  iq_push;
  rpr_item_t             iq_item;
  logic                  iq_full;
  logic                  iq_empty;
  logic                  iq_pop;
  logic [ITEM_W-1:0]     iq_rdata;
  rpr_res_t              res;
  logic                  oq_full;
  logic [OUT_W-1:0]      oq_rdata;

  // Configuration registers; each write lands in the register it names.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width   <= SW_W'(1);
      cfg.start_position <= '0;
      cfg.position_step  <= STEP_W'(65536);
      cfg.tap_count      <= TC_REG_W'(2);
    end else if (cfg_write) begin
      case (rpr_cfg_idx_t'(cfg_index))
        CFG_SOURCE_WIDTH:   cfg.source_width   <= cfg_data[SW_W-1:0];
        CFG_START_POSITION: cfg.start_position <= cfg_data[POS_W-1:0];
        CFG_POSITION_STEP:  cfg.position_step  <= cfg_data[STEP_W-1:0];
        CFG_TAP_COUNT:      cfg.tap_count      <= cfg_data[TC_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpr_front #(
    .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH),
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .push(push),
    .full(full),
    .op(op),
    .index(index),
    .phase(phase),
    .tap(tap),
    .pixel(pixel),
    .coefficient(coefficient),
    .iq_push(iq_push),
    .iq_item(iq_item),
    .iq_full(iq_full)
  );

  // Item queue between front and back.
  rpr_fifo #(
    .DATA_W(ITEM_W),
    .DEPTH(ITEM_QUEUE_DEPTH)
  ) u_item_queue (
    .clk(clk),
    .rst(rst),
    .wr(iq_push),
    .wdata(iq_item),
    .full(iq_full),
    .rd(iq_pop),
    .rdata(iq_rdata),
    .empty(iq_empty)
  );

  rpr_back #(
    .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH),
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_empty(iq_empty),
    .q_item(rpr_item_t'(iq_rdata)),
    .q_pop(iq_pop),
    .oq_full(oq_full),
    .res(res)
  );

  // Result queue; the back end starts a compute only when it has room.
  rpr_fifo #(
    .DATA_W(OUT_W),
    .DEPTH(RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk(clk),
    .rst(rst),
    .wr(res.push),
    .wdata({res.pixel, res.index}),
    .full(oq_full),
    .rd(pop),
    .rdata(oq_rdata),
    .empty(empty)
  );

  assign out_pixel = oq_rdata[OUT_W-1:IDX_W];
  assign out_index = oq_rdata[IDX_W-1:0];

  // The front never hands an item to a full item queue.
  `RPR_ASSERT_SAME(a_item_queue_room, iq_push, !iq_full, "item pushed into full queue")
  // The slot reserved at compute start is still free when the result arrives.
  `RPR_ASSERT_SAME(a_result_queue_room, res.push, !oq_full, "result lost to full queue")
  // A finished result becomes visible on the result port in the cycle after its push.
  `RPR_ASSERT_NEXT(a_result_visible, res.push, !empty, "result not visible after push")

endmodule

[rtl/core/rpr_fifo.sv]
// Small register-based first-in first-out queue.
module rpr_fifo
  import rpr_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              rd,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/rpr_front.sv]
// Front end: accepts items, drops ignored ones and forms the source position.
module rpr_front
  import rpr_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rpr_cfg_t                 cfg,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               op,
  input  logic [IDX_W-1:0]         index,
  input  logic [PHASE_W-1:0]       phase,
  input  logic [TAPNUM_W-1:0]      tap,
  input  logic [PIX_W-1:0]         pixel,
  input  logic signed [COEF_W-1:0] coefficient,
  output logic                     iq_push,
  output rpr_item_t                iq_item,
  input  logic                     iq_full
);

  logic                      fe_vld;
  rpr_item_t                 fe_item;
  rpr_item_t                 item_next;
  logic                      keep;
  logic                      in_acc;
  logic [STEP_W+IDX_W-1:0]   prod;
  logic [POS_W-1:0]          pos;

  assign in_acc = push && !full;
  assign full   = fe_vld && iq_full;
  assign prod   = cfg.position_step * index;
  assign pos    = cfg.start_position + prod[POS_W-1:0];

  always_comb begin
    item_next       = '0;
    item_next.index = index;
    item_next.phase = phase;
    item_next.tap   = tap;
    item_next.data  = 16'(pixel);
    item_next.base  = pos[POS_W-1:16];
    item_next.kind  = K_PIX;
    keep            = 1'b0;
    case (op)
      OP_LOAD_PIXEL: begin
        keep = (32'(index) < MAX_SOURCE_WIDTH);
      end
      OP_LOAD_COEF: begin
        item_next.kind = K_COEF;
        item_next.data = coefficient;
        keep           = (32'(tap) < MAX_TAPS);
      end
      OP_COMPUTE: begin
        item_next.kind  = K_COMP;
        item_next.phase = pos[15:8];
        keep            = (32'(index) < MAX_DEST_WIDTH);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_vld <= 1'b0;
    end else if (!fe_vld || !iq_full) begin
      fe_vld <= in_acc && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fe_item <= item_next;
    end
  end

  assign iq_push = fe_vld && !iq_full;
  assign iq_item = fe_item;

endmodule

[rtl/core/rpr_back.sv]
// Back end: row and coefficient stores and the shared multiply-accumulate.
module rpr_back
  import rpr_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic      clk,
  input  logic      rst,
  input  rpr_cfg_t  cfg,
  input  logic      q_empty,
  input  rpr_item_t q_item,
  output logic      q_pop,
  input  logic      oq_full,
  output rpr_res_t  res
);

  localparam int SA_W = $clog2(MAX_SOURCE_WIDTH);
  localparam int CA_W = $clog2(PHASES * MAX_TAPS);
  localparam int TAP_W = $clog2(MAX_TAPS);
  localparam int TC_W = $clog2(MAX_TAPS + 1);
  localparam int CMP_W = 20;
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ISSUE,
    B_DRAIN
  } state_t;

  logic [PIX_W-1:0]  row_mem  [MAX_SOURCE_WIDTH];
  logic [COEF_W-1:0] coef_mem [PHASES * MAX_TAPS];

  state_t                    state;
  logic [TAP_W-1:0]          tap_i;
  logic [TAP_W-1:0]          tap_last;
  logic signed [15:0]        base_r;
  logic [PHASE_W-1:0]        phase_r;
  logic [IDX_W-1:0]          index_r;
  logic                      one_px;
  logic                      rd_vld;
  logic                      rd_last;
  logic [PIX_W-1:0]          row_q;
  logic [COEF_W-1:0]         coef_q;
  logic                      mul_vld;
  logic                      mul_last;
  logic signed [PROD_W-1:0]  mul_q;
  logic [PIX_W-1:0]          mul_pix;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   total;

  logic [CMP_W-1:0]          width_eff;
  logic [TC_W-1:0]           taps_eff;
  logic signed [CMP_W-1:0]   s_pos;
  logic signed [CMP_W-1:0]   s_last;
  logic [SA_W-1:0]           row_raddr;
  logic [CA_W-1:0]           coef_raddr;
  logic                      start_comp;
  logic                      issue;
  logic [PIX_W-1:0]          sat_pix;

  // Effective width and tap count after range clamping.
  always_comb begin
    if (cfg.source_width == '0) begin
      width_eff = CMP_W'(1);
    end else if (32'(cfg.source_width) > MAX_SOURCE_WIDTH) begin
      width_eff = CMP_W'(MAX_SOURCE_WIDTH);
    end else begin
      width_eff = CMP_W'(cfg.source_width);
    end
    if (cfg.tap_count == '0) begin
      taps_eff = TC_W'(1);
    end else if (32'(cfg.tap_count) > MAX_TAPS) begin
      taps_eff = TC_W'(MAX_TAPS);
    end else begin
      taps_eff = TC_W'(cfg.tap_count);
    end
  end

  // Tap position clamped to the row.
  always_comb begin
    s_pos  = CMP_W'(base_r) + $signed(CMP_W'(tap_i));
    s_last = $signed(width_eff) - CMP_W'(1);
    if (s_pos < 0) begin
      row_raddr = '0;
    end else if (s_pos > s_last) begin
      row_raddr = SA_W'(s_last);
    end else begin
      row_raddr = SA_W'(s_pos);
    end
    coef_raddr = CA_W'(phase_r) * CA_W'(MAX_TAPS) + CA_W'(tap_i);
  end

  assign start_comp = (state == B_IDLE) && !q_empty && (q_item.kind == K_COMP) && !oq_full;
  assign q_pop      = (state == B_IDLE) && !q_empty && ((q_item.kind != K_COMP) || !oq_full);
  assign issue      = (state == B_ISSUE);

  always_ff @(posedge clk) begin
    if ((state == B_IDLE) && !q_empty && (q_item.kind == K_PIX)) begin
      row_mem[SA_W'(q_item.index)] <= q_item.data[PIX_W-1:0];
    end
    row_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if ((state == B_IDLE) && !q_empty && (q_item.kind == K_COEF)) begin
      coef_mem[CA_W'(q_item.phase) * CA_W'(MAX_TAPS) + CA_W'(q_item.tap)] <= q_item.data;
    end
    coef_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      rd_vld   <= 1'b0;
      rd_last  <= 1'b0;
      mul_vld  <= 1'b0;
      mul_last <= 1'b0;
      tap_i    <= '0;
    end else begin
      rd_vld   <= issue;
      rd_last  <= issue && (tap_i == tap_last);
      mul_vld  <= rd_vld;
      mul_last <= rd_vld && rd_last;
      case (state)
        B_IDLE: begin
          if (start_comp) begin
            state <= B_ISSUE;
            tap_i <= '0;
          end
        end
        B_ISSUE: begin
          if (tap_i == tap_last) begin
            state <= B_DRAIN;
          end else begin
            tap_i <= tap_i + TAP_W'(1);
          end
        end
        B_DRAIN: begin
          if (mul_vld && mul_last) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Payload of the compute pipeline; no reset needed.
  always_ff @(posedge clk) begin
    if (start_comp) begin
      base_r   <= q_item.base;
      phase_r  <= q_item.phase;
      index_r  <= q_item.index;
      one_px   <= (width_eff == CMP_W'(1));
      tap_last <= (width_eff == CMP_W'(1)) ? '0 : TAP_W'(taps_eff - TC_W'(1));
      acc      <= ACC_W'(ROUND_BIAS);
    end else if (mul_vld && !mul_last) begin
      acc <= total;
    end
    mul_q   <= $signed({1'b0, row_q}) * $signed(coef_q);
    mul_pix <= row_q;
  end

  assign total = acc + ACC_W'(mul_q);

  always_comb begin
    if (total[ACC_W-1]) begin
      sat_pix = '0;
    end else if (|total[ACC_W-2:FRAC_BITS+PIX_W]) begin
      sat_pix = PIX_W'(PIXEL_MAX);
    end else begin
      sat_pix = total[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  assign res.push  = mul_vld && mul_last;
  assign res.pixel = one_px ? mul_pix : sat_pix;
  assign res.index = index_r;

endmodule
